>>> rtl/core/prq_pkg.sv
// Package for the priority ready queue: sizes, request codes and the
// structs shared by the sequencer, the slot store and the top level.
// Depends on nothing.
package prq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TASK_W      = 8;
   localparam int PRIO_W      = 8;
   localparam int COUNT_OUT_W = 4;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [PRIO_W-1:0] task_priority;
   } slot_type;

   typedef struct packed {
      logic        req_type;
      slot_type    slot;
   } request_type;

   typedef struct packed {
      logic        wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_type    wr_data;
      logic        rd_en;
      logic [IDX_W-1:0] rd_addr;
   } store_ctl_type;

   typedef struct packed {
      logic                   head_valid;
      logic [TASK_W-1:0]      head_task;
      logic [PRIO_W-1:0]      head_priority;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   push_dropped;
   } result_type;

endpackage

>>> rtl/core/prq_if.sv
// Handshake channels of the priority ready queue: request and response.
// Depends on prq_pkg for field widths.
interface prq_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [prq_pkg::TASK_W-1:0]  task_id;
   logic [prq_pkg::PRIO_W-1:0]  task_priority;

   modport source (output valid, output req_type, output task_id,
                   output task_priority, input ready);
   modport sink   (input valid, input req_type, input task_id,
                   input task_priority, output ready);
endinterface

interface prq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             head_valid;
   logic [prq_pkg::TASK_W-1:0]       head_task;
   logic [prq_pkg::PRIO_W-1:0]       head_priority;
   logic [prq_pkg::COUNT_OUT_W-1:0]  entry_count;
   logic                             push_dropped;

   modport source (output valid, output head_valid, output head_task,
                   output head_priority, output entry_count,
                   output push_dropped, input ready);
   modport sink   (input valid, input head_valid, input head_task,
                   input head_priority, input entry_count,
                   input push_dropped, output ready);
endinterface

>>> rtl/core/prq_store.sv
// Slot store of the priority ready queue: one write and one registered read
// per cycle. Depends on prq_pkg.
module prq_store (
   input  logic                    clock,
   input  prq_pkg::store_ctl_type  ctl,
   output prq_pkg::slot_type       rd_data
);

   prq_pkg::slot_type mem_ff [prq_pkg::QUEUE_DEPTH];
   prq_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/prq_seq.sv
// Sequencer of the priority ready queue: walks the slot store one entry at a
// time with a single priority comparator. Depends on prq_pkg and prq_store.
module prq_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  prq_pkg::request_type   req_word,
   output logic                   done,
   input  logic                   done_ack,
   output prq_pkg::result_type    result
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PREAD = 4'd1;
   localparam logic [3:0] ST_PCMP  = 4'd2;
   localparam logic [3:0] ST_PINS  = 4'd3;
   localparam logic [3:0] ST_POPR  = 4'd4;
   localparam logic [3:0] ST_POPW  = 4'd5;
   localparam logic [3:0] ST_HEAD  = 4'd6;
   localparam logic [3:0] ST_HWAIT = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]                  state_ff, state_in;
   logic [prq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [prq_pkg::IDX_W-1:0]   idx_ff, idx_in;
   prq_pkg::slot_type           new_ff, new_in;
   logic                        dropped_ff, dropped_in;
   prq_pkg::result_type         result_ff, result_in;
   prq_pkg::store_ctl_type      ctl;
   prq_pkg::slot_type           rd_data;
   logic                        moves_down;
   logic [prq_pkg::CNT_W-1:0]   idx_next_wide;

   prq_store u_store (
      .clock   (clock),
      .ctl     (ctl),
      .rd_data (rd_data)
   );

   // The shared comparator: a stored entry of equal or lower priority
   // gives way to the new one.
   assign moves_down    = rd_data.task_priority <= new_ff.task_priority;
   assign idx_next_wide = prq_pkg::CNT_W'(idx_ff) + prq_pkg::CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      new_in     = new_ff;
      dropped_in = dropped_ff;
      result_in  = result_ff;
      ctl        = '0;
      ctl.wr_data = new_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               new_in     = req_word.slot;
               dropped_in = 1'b0;
               if (req_word.req_type == prq_pkg::REQ_PUSH) begin
                  if (count_ff == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH)) begin
                     dropped_in = 1'b1;
                     state_in   = ST_HEAD;
                  end else begin
                     idx_in   = prq_pkg::IDX_W'(count_ff);
                     state_in = (count_ff == '0) ? ST_PINS : ST_PREAD;
                  end
               end else begin
                  idx_in = prq_pkg::IDX_W'(1);
                  if (count_ff == '0) begin
                     state_in = ST_HEAD;
                  end else if (count_ff == prq_pkg::CNT_W'(1)) begin
                     count_in = '0;
                     state_in = ST_HEAD;
                  end else begin
                     state_in = ST_POPR;
                  end
               end
            end
         end
         ST_PREAD: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = idx_ff - prq_pkg::IDX_W'(1);
            state_in    = ST_PCMP;
         end
         ST_PCMP: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = idx_ff;
            if (moves_down) begin
               ctl.wr_data = rd_data;
               idx_in      = idx_ff - prq_pkg::IDX_W'(1);
               state_in    = (idx_ff == prq_pkg::IDX_W'(1)) ? ST_PINS : ST_PREAD;
            end else begin
               count_in = count_ff + prq_pkg::CNT_W'(1);
               state_in = ST_HEAD;
            end
         end
         ST_PINS: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = idx_ff;
            count_in    = count_ff + prq_pkg::CNT_W'(1);
            state_in    = ST_HEAD;
         end
         ST_POPR: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = idx_ff;
            state_in    = ST_POPW;
         end
         ST_POPW: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = idx_ff - prq_pkg::IDX_W'(1);
            ctl.wr_data = rd_data;
            if (idx_next_wide == count_ff) begin
               count_in = count_ff - prq_pkg::CNT_W'(1);
               state_in = ST_HEAD;
            end else begin
               idx_in   = idx_ff + prq_pkg::IDX_W'(1);
               state_in = ST_POPR;
            end
         end
         ST_HEAD: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = '0;
            state_in    = ST_HWAIT;
         end
         ST_HWAIT: begin
            result_in.head_valid    = count_ff != '0;
            result_in.head_task     = (count_ff != '0) ? rd_data.task_id : '0;
            result_in.head_priority = (count_ff != '0) ? rd_data.task_priority : '0;
            result_in.entry_count   = prq_pkg::COUNT_OUT_W'(count_ff);
            result_in.push_dropped  = dropped_ff;
            state_in                = ST_DONE;
         end
         ST_DONE: begin
            if (done_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff     <= idx_in;
      new_ff     <= new_in;
      dropped_ff <= dropped_in;
      result_ff  <= result_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign done      = state_ff == ST_DONE;
   assign result    = result_ff;

endmodule

>>> rtl/core/priority_ready_queue_top.sv
// Priority ready queue: a queue of task numbers kept sorted by priority.
// A request word on req_port either pushes a task (req_type 0) or pops the
// head (req_type 1). Each request yields exactly one response word on
// rsp_port carrying the head task and priority after the operation, the
// entry count and a flag set when a push met a full queue and was dropped.
// Among equal priorities the most recently pushed task is served first.
// The slots sit in a small memory walked by a sequencer with one priority
// comparator, which reads and then writes one entry at a time. A push moves
// entries of equal or lower priority down one slot from the tail and writes
// the new task into the gap; a pop moves every remaining entry up one slot.
// Both then read the head for the response. The block takes one request at
// a time and is not ready while a request is being worked on.
// Reset empties the queue; slot contents are not cleared, since no entry
// at or above the count reaches a response. The response sits in an output
// register, so the sequencer may finish and accept the next request while
// a response still waits; if the receiver stalls for longer, the next
// response is held inside until the register is free.
module priority_ready_queue_top (
   input  logic        clock,
   input  logic        reset,
   prq_req_if.sink     req_port,
   prq_rsp_if.source   rsp_port
);

   prq_pkg::request_type req_word;
   prq_pkg::result_type  result;
   prq_pkg::result_type  rsp_word_ff, rsp_word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 done;
   logic                 done_ack;

   assign req_word.req_type           = req_port.req_type;
   assign req_word.slot.task_id       = req_port.task_id;
   assign req_word.slot.task_priority = req_port.task_priority;

   prq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .req_word  (req_word),
      .done      (done),
      .done_ack  (done_ack),
      .result    (result)
   );

   // The output register is free when empty or being emptied this cycle.
   assign done_ack = done && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_ack) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.head_valid    = rsp_word_ff.head_valid;
   assign rsp_port.head_task     = rsp_word_ff.head_task;
   assign rsp_port.head_priority = rsp_word_ff.head_priority;
   assign rsp_port.entry_count   = rsp_word_ff.entry_count;
   assign rsp_port.push_dropped  = rsp_word_ff.push_dropped;

endmodule

>>> tb/priority_ready_queue_monitor.sv
`timescale 1ns / 1ps
// Watches both channels of the priority ready queue, predicts each response word and
// compares it with the word the block returns. Depends on prq_pkg and prq_if.
module priority_ready_queue_monitor (
   input  logic        clock,
   input  logic        reset,
   prq_req_if          req_mon,
   prq_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned heads_pending
);

   logic [prq_pkg::TASK_W-1:0] queued_task [prq_pkg::QUEUE_DEPTH];
   logic [prq_pkg::PRIO_W-1:0] queued_prio [prq_pkg::QUEUE_DEPTH];
   int                         queued_count;
   int unsigned                mismatches;
   prq_pkg::result_type        expected_heads [$];

   // Applies one request to the shadow queue and returns the head it should leave.
   function automatic prq_pkg::result_type apply_request(
         logic kind, logic [prq_pkg::TASK_W-1:0] id, logic [prq_pkg::PRIO_W-1:0] prio);
      prq_pkg::result_type head;
      int                  pos;
      int                  i;
      head = '0;
      if (kind == prq_pkg::REQ_PUSH) begin
         if (queued_count >= prq_pkg::QUEUE_DEPTH) begin
            head.push_dropped = 1'b1;
         end else begin
            // The new entry goes ahead of the first entry of equal or lower priority.
            pos = queued_count;
            for (i = queued_count - 1; i >= 0; i--) begin
               if (queued_prio[i] <= prio) begin
                  pos = i;
               end
            end
            for (i = queued_count; i > pos; i--) begin
               queued_task[i] = queued_task[i-1];
               queued_prio[i] = queued_prio[i-1];
            end
            queued_task[pos] = id;
            queued_prio[pos] = prio;
            queued_count++;
         end
      end else if (queued_count > 0) begin
         for (i = 1; i < queued_count; i++) begin
            queued_task[i-1] = queued_task[i];
            queued_prio[i-1] = queued_prio[i];
         end
         queued_count--;
      end
      if (queued_count > 0) begin
         head.head_valid    = 1'b1;
         head.head_task     = queued_task[0];
         head.head_priority = queued_prio[0];
      end
      head.entry_count = prq_pkg::COUNT_OUT_W'(queued_count);
      return head;
   endfunction

   function automatic int field_differs(string field, int unsigned want, int unsigned got);
      if (want == got) begin
         return 0;
      end
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      prq_pkg::result_type oldest;
      if (reset) begin
         queued_count = 0;
         mismatches   = 0;
         expected_heads.delete();
      end else begin
         // A response word always belongs to an earlier request, so it is checked first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_heads.size() == 0) begin
               $display("%0t: response word with none expected, actual task %0d prio %0d",
                        $time, rsp_mon.head_task, rsp_mon.head_priority);
               mismatches++;
            end else begin
               oldest = expected_heads.pop_front();
               mismatches += field_differs("head_valid", oldest.head_valid,
                                           rsp_mon.head_valid);
               mismatches += field_differs("head_task", oldest.head_task,
                                           rsp_mon.head_task);
               mismatches += field_differs("head_priority", oldest.head_priority,
                                           rsp_mon.head_priority);
               mismatches += field_differs("entry_count", oldest.entry_count,
                                           rsp_mon.entry_count);
               mismatches += field_differs("push_dropped", oldest.push_dropped,
                                           rsp_mon.push_dropped);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_heads.push_back(apply_request(req_mon.req_type, req_mon.task_id,
                                                   req_mon.task_priority));
         end
      end
      fail_count    <= mismatches;
      heads_pending <= expected_heads.size();
   end

endmodule

>>> tb/priority_ready_queue_top_test.sv
`timescale 1ns / 1ps
// Top of the priority ready queue testbench: clock, reset, request stimulus and
// response back-pressure. Depends on prq_pkg, prq_if, the block and its monitor.
module priority_ready_queue_top_test;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int          RANDOM_WORDS = 1700;
   localparam int          DRAIN_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        calm;
   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned heads_pending;

   prq_req_if req_chan ();
   prq_rsp_if rsp_chan ();

   priority_ready_queue_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_chan),
      .rsp_port (rsp_chan)
   );

   priority_ready_queue_monitor head_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .heads_pending (heads_pending)
   );

   // A 4 ns clock, starting low so that the first event is a rising edge at 2 ns.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The cycle counter is the only guard against a hung handshake.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // The receiver stalls with a chance of about 36 in a hundred, except during the calm
   // stretch, where it takes every response word as soon as it is offered. The
   // value changes only at the falling edge, so the block samples a settled level.
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= 36);
   end

   // Offers one request word and returns at the rising edge that accepts it. Any idle
   // cycles come first, with valid low; valid is only ever set once per falling edge,
   // so back-to-back words keep it high without a glitch.
   task automatic send_request(input logic kind, input logic [prq_pkg::TASK_W-1:0] id,
                               input logic [prq_pkg::PRIO_W-1:0] prio);
      if (!calm) begin
         while ($urandom_range(99) < 36) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid         <= 1'b1;
      req_chan.req_type      <= kind;
      req_chan.task_id       <= id;
      req_chan.task_priority <= prio;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int          push_bias;
      logic        kind;
      logic [7:0]  prio;
      reset                  = 1'b1;
      calm                   = 1'b0;
      req_chan.valid         = 1'b0;
      req_chan.req_type      = prq_pkg::REQ_PUSH;
      req_chan.task_id       = '0;
      req_chan.task_priority = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A pop on the empty queue must change nothing.
      send_request(prq_pkg::REQ_POP, 8'hA5, 8'h5A);
      // The lowest and highest priorities, then a tie at the top: the newer task
      // with equal priority has to overtake the older one.
      send_request(prq_pkg::REQ_PUSH, 8'h00, 8'h00);
      send_request(prq_pkg::REQ_PUSH, 8'hFF, 8'hFF);
      send_request(prq_pkg::REQ_PUSH, 8'h55, 8'hFF);
      // A tie at the bottom, then entries that land in the middle.
      send_request(prq_pkg::REQ_PUSH, 8'hAA, 8'h00);
      send_request(prq_pkg::REQ_PUSH, 8'h01, 8'h80);
      send_request(prq_pkg::REQ_PUSH, 8'h0F, 8'h01);
      send_request(prq_pkg::REQ_PUSH, 8'hF0, 8'hFE);
      send_request(prq_pkg::REQ_PUSH, 8'h07, 8'h80);
      // The queue is now full, so both of these are dropped and flagged.
      send_request(prq_pkg::REQ_PUSH, 8'hFF, 8'hFF);
      send_request(prq_pkg::REQ_PUSH, 8'h3C, 8'h00);
      // Drain to empty, where the head reads zero, and pop once more past empty.
      repeat (prq_pkg::QUEUE_DEPTH + 1) send_request(prq_pkg::REQ_POP, 8'hFF, 8'hFF);
      send_request(prq_pkg::REQ_PUSH, 8'h80, 8'hFF);
      send_request(prq_pkg::REQ_POP, 8'h00, 8'h00);

      // Random part. The push bias changes every 60 words, so the queue swings
      // between full and empty and spends time in between. Half the priorities come
      // from four values only, which makes ties common.
      push_bias = 50;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(4))
               0: begin
                  push_bias = 90;
               end
               1: begin
                  push_bias = 10;
               end
               2: begin
                  push_bias = 70;
               end
               3: begin
                  push_bias = 30;
               end
               default: begin
                  push_bias = 50;
               end
            endcase
         end
         calm = (n >= 700) && (n < 900);
         kind = ($urandom_range(99) < push_bias) ? prq_pkg::REQ_PUSH : prq_pkg::REQ_POP;
         prio = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(3) * 85);
         send_request(kind, 8'($urandom_range(255)), prio);
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      calm = 1'b0;

      // Wait for every expected response word, then allow the block's latency in
      // case a stray word is still on its way.
      while (heads_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
